// File: rtl/hcbp_pkg.sv
// Shared widths and opcode codes for the Huffman code bit packer.
// No dependencies; used by the top level, its port checker and the testbench.
package hcbp_pkg;

  localparam int OPC_W   = 2;
  localparam int SYM_W   = 8;
  localparam int CLEN_W  = 6;
  localparam int CODE_W  = 32;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 40;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int SUM_W   = 6;
  localparam int REM_W   = 3;

  localparam int TABLE_DEPTH = 256;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [OPC_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OPC_W-1:0] OP_ENCODE = 2'd1;
  localparam logic [OPC_W-1:0] OP_FLUSH  = 2'd2;

endpackage

// File: rtl/huffman_code_bit_packer.sv
// Huffman code bit packer: code table memory, packing accumulator, output register.
// Depends on hcbp_pkg.
//
//   channel | handshake           | payload
//   request | in_valid, in_stall  | opcode, symbol, code_length, code_bits
//   result  | out_valid, out_stall| out_byte, byte_valid, total_bits, last
//
// A request is registered together with its code table read before the packer takes it.
// An encode that completes k bytes (k up to 4) holds the packer until they are sent,
// one byte a cycle through the output register while out_stall allows; a flush sends one.
// A new request is taken every cycle while the packer keeps up.
// Reset clears pend, count, bit_total, rem and both valid flags; the table stays as written.
// out_stall holds the output register and, in turn, the packer and the request side.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hcbp_pkg::OPC_W-1:0]      opcode,
  input  logic [hcbp_pkg::SYM_W-1:0]      symbol,
  input  logic [hcbp_pkg::CLEN_W-1:0]     code_length,
  input  logic [hcbp_pkg::CODE_W-1:0]     code_bits,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hcbp_pkg::BYTE_W-1:0]     out_byte,
  output logic                            byte_valid,
  output logic [hcbp_pkg::TOTAL_W-1:0]    total_bits,
  output logic                            last
);
  import hcbp_pkg::*;

  localparam int LEN_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int LEN_W   = $clog2(LEN_CAP + 1);
  localparam int ENTRY_W = LEN_W + CODE_W;

  logic [ENTRY_W-1:0] code_table [TABLE_DEPTH];
  logic [ENTRY_W-1:0] entry_rd;
  logic [ENTRY_W-1:0] entry_wr;
  logic [CLEN_W-1:0]  len_capped;
  logic [2*CODE_W-1:0] code_shifted;

  logic               in_accept;
  logic               s1_valid;
  logic [OPC_W-1:0]   s1_op;

  logic [PEND_W-1:0]  pend, pend_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [TOTAL_W-1:0] bit_total, bit_total_next;
  logic [ACC_W-1:0]   acc, acc_next;
  logic [REM_W-1:0]   rem, rem_next;
  logic               pk_bv, pk_bv_next;
  logic [TOTAL_W-1:0] pk_total, pk_total_next;

  logic               out_ready;
  logic               emit;
  logic               take;

  logic [SUM_W-1:0]   e_len;
  logic [CODE_W-1:0]  e_code;
  logic [ACC_W-1:0]   merged;
  logic [ACC_W-1:0]   drained;
  logic [SUM_W-1:0]   sum;
  logic [REM_W-1:0]   full;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] tot_sat;

  assign out_ready = !out_valid || !out_stall;
  assign emit      = (rem != '0) && out_ready;
  assign take      = s1_valid && ((rem == '0) || ((rem == REM_W'(1)) && emit));
  assign in_stall  = s1_valid && !take;
  assign in_accept = in_valid && !in_stall;

  // store codes left-aligned so encode needs one right shift
  assign len_capped   = (code_length > CLEN_W'(LEN_CAP)) ? CLEN_W'(LEN_CAP) : code_length;
  assign code_shifted = {{CODE_W{1'b0}}, code_bits} << (CLEN_W'(CODE_W) - len_capped);
  assign entry_wr     = {len_capped[LEN_W-1:0], code_shifted[CODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (opcode == OP_LOAD) begin
        code_table[symbol] <= entry_wr;
      end
      entry_rd <= code_table[symbol];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op <= opcode;
    end
  end

  assign e_len   = SUM_W'(entry_rd[ENTRY_W-1 -: LEN_W]);
  assign e_code  = entry_rd[CODE_W-1:0];
  assign merged  = {pend, {CODE_W{1'b0}}} | ({e_code, {PEND_W{1'b0}}} >> count);
  assign sum     = SUM_W'(count) + e_len;
  assign full    = sum[SUM_W-1:CNT_W];
  assign drained = merged << {full, 3'b000};
  assign tot_sum = {1'b0, bit_total} + (TOTAL_W+1)'(e_len);
  assign tot_sat = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];

  always_comb begin
    pend_next      = pend;
    count_next     = count;
    bit_total_next = bit_total;
    rem_next       = rem - REM_W'(emit);
    acc_next       = emit ? (acc << BYTE_W) : acc;
    pk_bv_next     = pk_bv;
    pk_total_next  = pk_total;
    if (take) begin
      case (s1_op)
        OP_ENCODE: begin
          pend_next      = drained[ACC_W-1 -: PEND_W];
          count_next     = sum[CNT_W-1:0];
          bit_total_next = tot_sat;
          rem_next       = full;
          acc_next       = merged;
          pk_bv_next     = 1'b1;
          pk_total_next  = tot_sat;
        end
        OP_FLUSH: begin
          pend_next      = '0;
          count_next     = '0;
          bit_total_next = '0;
          rem_next       = REM_W'(1);
          acc_next       = {pend, {CODE_W{1'b0}}};
          pk_bv_next     = (count != '0);
          pk_total_next  = bit_total;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      count     <= '0;
      bit_total <= '0;
      rem       <= '0;
    end else begin
      pend      <= pend_next;
      count     <= count_next;
      bit_total <= bit_total_next;
      rem       <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    acc      <= acc_next;
    pk_bv    <= pk_bv_next;
    pk_total <= pk_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= acc[ACC_W-1 -: BYTE_W];
      byte_valid <= pk_bv;
      total_bits <= pk_total;
      last       <= (rem == REM_W'(1));
    end
  end

endmodule

// File: rtl/hcbp_check.sv
// Port-level checker for the Huffman code bit packer result channel.
// Depends on hcbp_pkg and huffman_code_bit_packer; attached by the bind at the end of this file.
module hcbp_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [hcbp_pkg::BYTE_W-1:0]  out_byte,
  input logic                         byte_valid,
  input logic [hcbp_pkg::TOTAL_W-1:0] total_bits,
  input logic                         last
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_byte) && $stable(byte_valid)
                               && $stable(total_bits) && $stable(last))
    else $error("result changed while stalled");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last)
    else $error("empty flush result not marked last");

  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == '0)
    else $error("empty flush result carries data");

endmodule

bind huffman_code_bit_packer hcbp_check u_hcbp_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_byte   (out_byte),
  .byte_valid (byte_valid),
  .total_bits (total_bits),
  .last       (last)
);

// File: sim/tb_huffman_code_bit_packer.sv
// Testbench for huffman_code_bit_packer: table loads, encodes and flushes checked
// byte by byte against an in-bench packer prediction, with random idling on both sides.
// Depends on hcbp_pkg and the huffman_code_bit_packer RTL.
module tb_huffman_code_bit_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import hcbp_pkg::*;

  localparam int MAX_LEN = 32;
  localparam int LEN_CAP = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
  localparam logic [OPC_W-1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 200000;
  localparam int TAIL_CYCLES = 16;
  localparam int RANDOM_ITEMS = 75;

  typedef struct {
    logic [BYTE_W-1:0]  data;
    logic               data_valid;
    logic [TOTAL_W-1:0] count;
    logic               is_last;
  } packed_byte_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OPC_W-1:0] opcode = OP_LOAD;
  logic [SYM_W-1:0] symbol = '0;
  logic [CLEN_W-1:0] code_length = '0;
  logic [CODE_W-1:0] code_bits = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic byte_valid;
  logic [TOTAL_W-1:0] total_bits;
  logic last;

  // Prediction state
  logic [CLEN_W-1:0] len_table [TABLE_DEPTH];
  logic [CODE_W-1:0] code_table [TABLE_DEPTH];
  bit loaded [TABLE_DEPTH];
  logic [SYM_W-1:0] loaded_syms [$];
  logic [BYTE_W-1:0] acc_bits = '0;
  int acc_count = 0;
  logic [TOTAL_W-1:0] coded_total = '0;
  packed_byte_t expected_bytes [$];

  bit pace_on = 1'b1;
  int failures = 0;
  int cycle_count = 0;
  int n_loads = 0;
  int n_encodes = 0;
  int n_flushes = 0;
  int n_ignored = 0;
  int n_checked = 0;
  int n_four_byte = 0;
  packed_byte_t got;

  huffman_code_bit_packer #(.MAX_CODE_LEN(MAX_LEN)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .symbol(symbol),
    .code_length(code_length),
    .code_bits(code_bits),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .byte_valid(byte_valid),
    .total_bits(total_bits),
    .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic push_result(logic [BYTE_W-1:0] data, logic data_valid, logic is_last);
    packed_byte_t r;
    r.data = data;
    r.data_valid = data_valid;
    r.count = coded_total;
    r.is_last = is_last;
    expected_bytes.push_back(r);
  endtask

  task automatic predict_packer(logic [OPC_W-1:0] op, logic [SYM_W-1:0] sym,
                                logic [CLEN_W-1:0] len, logic [CODE_W-1:0] code);
    logic [CLEN_W-1:0] use_len;
    logic [CODE_W-1:0] use_code;
    logic [BYTE_W-1:0] done_bytes [4];
    int nb;
    nb = 0;
    case (op)
      OP_LOAD: begin
        use_len = (len > LEN_CAP) ? CLEN_W'(LEN_CAP) : len;
        use_code = (use_len >= CODE_W) ? code : code & ((32'd1 << use_len) - 32'd1);
        len_table[sym] = use_len;
        code_table[sym] = use_code;
        if (!loaded[sym]) begin
          loaded[sym] = 1'b1;
          loaded_syms.push_back(sym);
        end
        n_loads++;
      end
      OP_ENCODE: begin
        use_len = len_table[sym];
        use_code = code_table[sym];
        for (int i = int'(use_len); i > 0; i--) begin
          acc_bits = {acc_bits[BYTE_W-2:0], use_code[i-1]};
          acc_count++;
          if (acc_count == BYTE_W) begin
            done_bytes[nb] = acc_bits;
            nb++;
            acc_bits = '0;
            acc_count = 0;
          end
        end
        if (TOTAL_MAX - coded_total < TOTAL_W'(use_len))
          coded_total = TOTAL_MAX;
        else
          coded_total = coded_total + TOTAL_W'(use_len);
        for (int k = 0; k < nb; k++)
          push_result(done_bytes[k], 1'b1, k == nb - 1);
        if (nb == 4)
          n_four_byte++;
        n_encodes++;
      end
      OP_FLUSH: begin
        if (acc_count > 0)
          push_result(acc_bits << (BYTE_W - acc_count), 1'b1, 1'b1);
        else
          push_result('0, 1'b0, 1'b1);
        acc_bits = '0;
        acc_count = 0;
        coded_total = '0;
        n_flushes++;
      end
      default: begin
        n_ignored++;
      end
    endcase
  endtask

  task automatic send_request(logic [OPC_W-1:0] op, logic [SYM_W-1:0] sym,
                              logic [CLEN_W-1:0] len, logic [CODE_W-1:0] code);
    if (pace_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 35);
    end
    in_valid <= 1'b1;
    opcode <= op;
    symbol <= sym;
    code_length <= len;
    code_bits <= code;
    do @(posedge clk); while (in_stall);
    predict_packer(op, sym, len, code);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  function automatic logic [SYM_W-1:0] pick_loaded();
    return loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
  endfunction

  task automatic test_table_load();
    send_request(OP_LOAD, 8'h00, 6'd1, 32'h0000_0001);
    send_request(OP_LOAD, 8'hFF, 6'd32, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 8'h80, 6'd63, 32'hA5A5_A5A5);
    send_request(OP_LOAD, 8'h7F, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_LOAD, 8'h55, 6'd5, 32'hFFFF_FFE3);
    send_request(OP_LOAD, 8'h2A, 6'd33, 32'h0000_0000);
    send_request(OP_LOAD, 8'h01, 6'd8, 32'h5A5A_5A3C);
  endtask

  task automatic test_empty_flush();
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_encode_extremes();
    send_request(OP_ENCODE, 8'h7F, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h01, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h80, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h55, 6'd0, 32'h0);
    send_request(OP_FLUSH, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h2A, 6'd0, 32'h0);
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_ignored_opcode();
    send_request(OP_ENCODE, 8'h55, 6'd0, 32'h0);
    send_request(OP_UNUSED, 8'hFF, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_UNUSED, 8'h00, 6'd1, 32'h0);
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_sender_pause();
    send_request(OP_ENCODE, 8'hFF, 6'd0, 32'h0);
    send_request(OP_ENCODE, 8'h00, 6'd0, 32'h0);
    wait_for_drain();
    send_request(OP_ENCODE, 8'h80, 6'd0, 32'h0);
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    logic [CLEN_W-1:0] len;
    sent = 0;
    while (sent < n_items) begin
      pace_on = !(sent >= 40 && sent < 70);
      if (sent == 30)
        wait_for_drain();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        len = ($urandom_range(0, 99) < 15) ? CLEN_W'($urandom_range(0, 63))
                                           : CLEN_W'($urandom_range(1, 20));
        send_request(OP_LOAD, SYM_W'($urandom_range(0, 255)), len, $urandom);
        sent++;
      end else if (pick < 85) begin
        send_request(OP_ENCODE, pick_loaded(), CLEN_W'($urandom), $urandom);
        sent++;
      end else if (pick < 95) begin
        send_request(OP_FLUSH, SYM_W'($urandom), CLEN_W'($urandom), $urandom);
        sent++;
      end else begin
        send_request(OP_UNUSED, SYM_W'($urandom), CLEN_W'($urandom), $urandom);
      end
    end
    pace_on = 1'b1;
    send_request(OP_FLUSH, 8'h00, 6'd0, 32'h0);
  endtask

  function automatic void check_field(string name, logic [TOTAL_W-1:0] want_v,
                                      logic [TOTAL_W-1:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end else begin
      out_stall <= !rst && pace_on && ($urandom_range(0, 99) < 35);
      if (!rst && out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected result, expected none actual byte %0h", $time, out_byte);
          failures++;
        end else begin
          got = expected_bytes.pop_front();
          check_field("out_byte", TOTAL_W'(got.data), TOTAL_W'(out_byte));
          check_field("byte_valid", TOTAL_W'(got.data_valid), TOTAL_W'(byte_valid));
          check_field("total_bits", got.count, total_bits);
          check_field("last", TOTAL_W'(got.is_last), TOTAL_W'(last));
          n_checked++;
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_table_load();
    test_empty_flush();
    test_encode_extremes();
    test_ignored_opcode();
    test_sender_pause();
    test_random_traffic(RANDOM_ITEMS);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("ran %0d loads, %0d encodes, %0d flushes, %0d ignored requests",
             n_loads, n_encodes, n_flushes, n_ignored);
    $display("checked %0d result bytes, %0d encodes produced four bytes",
             n_checked, n_four_byte);
    if (failures == 0 && expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
